// ----- src/rthsl_pkg.sv -----
// Package for the rotated-cube RGB to HSL converter.
// Holds widths, constants, the arctangent table and the pipeline payload types.
// No dependencies.
`default_nettype none
package rthsl_pkg;

    localparam int CordicSteps = 24;
    localparam int SqrtSteps   = 25;
    localparam int DivSteps    = 16;
    localparam int CordicW     = 38;
    localparam int LightShift  = 37;

    localparam logic signed [CordicW-1:0] SQRT3_Q24   = CordicW'(29058991);
    localparam logic [26:0]               LIGHT_RECIP = 27'd89829382;
    localparam logic [31:0]               ACC_POS_QTR = 32'h4000_0000;
    localparam logic [31:0]               ACC_NEG_QTR = 32'hC000_0000;

    // atan(2^-i) in units of pi/2^31
    localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    // payload through the CORDIC / square-root row
    typedef struct packed {
        logic                      grey;
        logic [16:0]               light;
        logic [8:0]                d;
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic [31:0]               acc;
        logic [15:0]               p;
        logic [25:0]               rem;
        logic [24:0]               root;
    } t_cpipe;

    // payload through the divider row
    typedef struct packed {
        logic        grey;
        logic [16:0] light;
        logic [31:0] acc;
        logic        ovf;
        logic [9:0]  dv;
        logic [25:0] n;
        logic [9:0]  rem;
        logic [15:0] q;
    } t_dpipe;

endpackage
`default_nettype wire

// ----- src/rthsl_if.sv -----
// Valid/ready channel interfaces: RGB pixel in, HSL result out.
// No dependencies.
`default_nettype none
interface rthsl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsl_hsl_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
    logic        hue_defined;
    modport source (output valid, output hue, output saturation, output lightness,
                    output hue_defined, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    input hue_defined, output ready);
endinterface
`default_nettype wire

// ----- src/rthsl_front.sv -----
// Front end: two stages forming chroma, P, lightness, divisor and CORDIC start.
// Depends on rthsl_pkg.
`default_nettype none
module rthsl_front
    import rthsl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_adv,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output logic [1:0]      o_valid,
    output t_cpipe          o_data
);
    logic                      r_v1, r_v2;
    logic [9:0]                r_sum, n_sum;
    logic signed [9:0]         r_dx, n_dx;
    logic signed [8:0]         r_dy, n_dy, r_rg, n_rg, r_rb, n_rb;
    logic signed [CordicW-1:0] r_ymul, n_ymul;
    logic                      r_grey, n_grey;
    t_cpipe                    r_data, n_data;

    logic signed [17:0]        sqa, sqb, sqc, psum;
    logic [26:0]               num;
    logic [53:0]               prod;
    logic signed [11:0]        dd;
    logic [9:0]                ad, dhalf;
    logic signed [CordicW-1:0] x0;

    always_comb begin
        n_sum  = 10'(i_red) + 10'(i_green) + 10'(i_blue);
        n_dx   = 10'(11'({i_red, 1'b0}) - 11'(i_green) - 11'(i_blue));
        n_dy   = 9'(9'(i_green) - 9'(i_blue));
        n_rg   = 9'(9'(i_red) - 9'(i_green));
        n_rb   = 9'(9'(i_red) - 9'(i_blue));
        n_ymul = CordicW'(n_dy) * SQRT3_Q24;
        n_grey = (i_red == i_green) && (i_green == i_blue);
    end

    always_comb begin
        sqa  = r_rg * r_rg;
        sqb  = r_rb * r_rb;
        sqc  = r_dy * r_dy;
        psum = sqa + sqb + sqc;
        num  = {r_sum, 17'b0} + 27'd765;
        prod = 54'(num) * 54'(LIGHT_RECIP);
        dd   = $signed({1'b0, r_sum, 1'b0}) - 12'sd765;
        ad   = dd[11] ? 10'(-dd) : 10'(dd);
        dhalf = (10'd765 - ad) >> 1;
        x0   = CordicW'(r_dx) <<< 24;

        n_data       = '0;
        n_data.grey  = r_grey;
        n_data.light = prod[53:LightShift];
        n_data.p     = psum[16:1];
        if (ad > 10'd255) begin
            n_data.d = (dhalf == 10'd0) ? 9'd1 : dhalf[8:0];
        end else begin
            n_data.d = 9'd255;
        end
        // fold left half-plane into the right one
        if (x0[CordicW-1] && !r_ymul[CordicW-1]) begin
            n_data.x   = r_ymul;
            n_data.y   = -x0;
            n_data.acc = ACC_POS_QTR;
        end else if (x0[CordicW-1]) begin
            n_data.x   = -r_ymul;
            n_data.y   = x0;
            n_data.acc = ACC_NEG_QTR;
        end else begin
            n_data.x   = x0;
            n_data.y   = r_ymul;
            n_data.acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_adv[0]) r_v1 <= i_valid;
            if (i_adv[1]) r_v2 <= r_v1;
        end
        if (i_adv[0]) begin
            r_sum  <= n_sum;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_rg   <= n_rg;
            r_rb   <= n_rb;
            r_ymul <= n_ymul;
            r_grey <= n_grey;
        end
        if (i_adv[1]) r_data <= n_data;
    end

    assign o_valid = {r_v2, r_v1};
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ----- src/rthsl_cell.sv -----
// One cell of the main row: a CORDIC vectoring step and a square-root digit.
// Depends on rthsl_pkg.
`default_nettype none
module rthsl_cell
    import rthsl_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  t_cpipe    i_data,
    output logic      o_valid,
    output t_cpipe    o_data
);
    logic                      r_valid;
    t_cpipe                    r_data, n_data;
    logic [1:0]                pair;
    logic [27:0]               rs;
    logic [26:0]               tr;
    logic signed [CordicW-1:0] xs, ys;

    // P holds the only nonzero radicand digits; the rest are zero
    if (K < 8) begin : g_pair
        assign pair = i_data.p[15-2*K -: 2];
    end else begin : g_zero
        assign pair = 2'b00;
    end

    always_comb begin
        n_data = i_data;
        rs = {i_data.rem, pair};
        tr = {i_data.root, 2'b01};
        if (rs >= {1'b0, tr}) begin
            n_data.rem  = 26'(rs - {1'b0, tr});
            n_data.root = {i_data.root[23:0], 1'b1};
        end else begin
            n_data.rem  = rs[25:0];
            n_data.root = {i_data.root[23:0], 1'b0};
        end
        xs = i_data.x >>> K;
        ys = i_data.y >>> K;
        if (K < CordicSteps) begin
            if (!i_data.y[CordicW-1]) begin
                n_data.x   = i_data.x + ys;
                n_data.y   = i_data.y - xs;
                n_data.acc = i_data.acc + ATAN_TAB[K % CordicSteps];
            end else begin
                n_data.x   = i_data.x - ys;
                n_data.y   = i_data.y + xs;
                n_data.acc = i_data.acc - ATAN_TAB[K % CordicSteps];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ----- src/rthsl_div_cell.sv -----
// One cell of the divider row: a restoring step producing quotient bit J.
// Depends on rthsl_pkg.
`default_nettype none
module rthsl_div_cell
    import rthsl_pkg::*;
#(
    parameter int J = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  t_dpipe    i_data,
    output logic      o_valid,
    output t_dpipe    o_data
);
    logic        r_valid;
    t_dpipe      r_data, n_data;
    logic [10:0] t;

    always_comb begin
        n_data = i_data;
        t = {i_data.rem, i_data.n[J]};
        if (t >= {1'b0, i_data.dv}) begin
            n_data.rem  = 10'(t - {1'b0, i_data.dv});
            n_data.q[J] = 1'b1;
        end else begin
            n_data.rem  = t[9:0];
            n_data.q[J] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ----- src/rgb_to_rotated_hsl_top.sv -----
// Top level of the rotated-cube RGB to HSL converter.
// Depends on rthsl_pkg, rthsl_if, rthsl_front, rthsl_cell, rthsl_div_cell.
//
// Usage:
//  - i_pix carries one 8-bit RGB pixel per transfer (valid/ready).
//  - o_hsl carries hue (signed binary angle, pi = 32768), saturation and
//    lightness (Q0.16, clamped to 65535) and hue_defined (0 for grey).
//  - One pixel per clock sustained while o_hsl.ready holds: every stage is
//    a register in a row of cells and a new transfer is taken each cycle.
//  - Stages from input to output: 2 front stages, 25 cells (24 CORDIC
//    steps alongside 25 square-root digits), 1 divider setup stage,
//    16 divider cells and the output register. The 25-digit square root
//    sets the depth of the cell row.
//  - Each stage advances when it is empty or its successor advances, so
//    bubbles are squeezed out; a receiver stall fills the row from the
//    output back, and i_pix.ready drops only when every stage holds a pixel.
//  - Synchronous reset (i_rst_n low) empties the row; no pixel in flight
//    survives it. There is no clearing pass and no configuration.
`default_nettype none
module rgb_to_rotated_hsl_top
    import rthsl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rthsl_pix_if.sink   i_pix,
    rthsl_hsl_if.source o_hsl
);
    localparam int CellBase = 2;
    localparam int PrepIdx  = CellBase + SqrtSteps;
    localparam int DivBase  = PrepIdx + 1;
    localparam int OutIdx   = DivBase + DivSteps;
    localparam int NumStg   = OutIdx + 1;

    logic [NumStg-1:0] w_v;
    logic [NumStg:0]   w_adv;
    t_cpipe            c_data [SqrtSteps+1];
    t_dpipe            d_data [DivSteps+1];

    // ready ripples back from the output
    assign w_adv[NumStg] = o_hsl.ready;
    for (genvar s = 0; s < NumStg; s++) begin : g_adv
        assign w_adv[s] = !w_v[s] || w_adv[s+1];
    end
    assign i_pix.ready = w_adv[0];

    rthsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv[1:0]),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_v[1:0]),
        .o_data  (c_data[0])
    );

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_cell
        rthsl_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv[CellBase+k]),
            .i_valid (w_v[CellBase+k-1]),
            .i_data  (c_data[k]),
            .o_valid (w_v[CellBase+k]),
            .o_data  (c_data[k+1])
        );
    end

    // divider setup: n = root + d over 2d, flag quotients that clamp
    logic   r_prep_v;
    t_dpipe r_prep, n_prep;
    always_comb begin
        n_prep       = '0;
        n_prep.grey  = c_data[SqrtSteps].grey;
        n_prep.light = c_data[SqrtSteps].light;
        n_prep.acc   = c_data[SqrtSteps].acc;
        n_prep.dv    = {c_data[SqrtSteps].d, 1'b0};
        n_prep.n     = 26'(c_data[SqrtSteps].root) + 26'(c_data[SqrtSteps].d);
        n_prep.ovf   = n_prep.n >= {n_prep.dv, 16'b0};
        n_prep.rem   = n_prep.n[25:16];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_v <= 1'b0;
        end else if (w_adv[PrepIdx]) begin
            r_prep_v <= w_v[PrepIdx-1];
        end
        if (w_adv[PrepIdx]) r_prep <= n_prep;
    end
    assign w_v[PrepIdx] = r_prep_v;
    assign d_data[0]    = r_prep;

    for (genvar j = 0; j < DivSteps; j++) begin : g_div
        rthsl_div_cell #(.J(DivSteps-1-j)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv[DivBase+j]),
            .i_valid (w_v[DivBase+j-1]),
            .i_data  (d_data[j]),
            .o_valid (w_v[DivBase+j]),
            .o_data  (d_data[j+1])
        );
    end

    // output register: rounding of hue, clamps, grey override
    logic        r_out_v;
    logic [15:0] r_hue, r_sat, r_light;
    logic        r_def;
    logic [31:0] hue_rnd;
    t_dpipe      fin;
    assign fin     = d_data[DivSteps];
    assign hue_rnd = fin.acc + 32'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv[OutIdx]) begin
            r_out_v <= w_v[OutIdx-1];
        end
        if (w_adv[OutIdx]) begin
            r_hue   <= fin.grey ? 16'd0 : hue_rnd[31:16];
            r_sat   <= fin.grey ? 16'd0 : (fin.ovf ? 16'hFFFF : fin.q);
            r_light <= fin.light[16] ? 16'hFFFF : fin.light[15:0];
            r_def   <= !fin.grey;
        end
    end
    assign w_v[OutIdx] = r_out_v;

    assign o_hsl.valid       = r_out_v;
    assign o_hsl.hue         = r_hue;
    assign o_hsl.saturation  = r_sat;
    assign o_hsl.lightness   = r_light;
    assign o_hsl.hue_defined = r_def;
endmodule
`default_nettype wire

// ----- src/rthsl_checker.sv -----
// Port-level checks for the converter, bound to the top level.
// Depends on rthsl_if through the bound top level ports.
`default_nettype none
module rthsl_sva (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_hue,
    input wire logic [15:0] i_sat,
    input wire logic        i_def
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transfer dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hue) && $stable(i_sat))
        else $error("stalled output changed");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_def |-> i_hue == 16'd0 && i_sat == 16'd0)
        else $error("grey pixel with nonzero hue or saturation");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind rgb_to_rotated_hsl_top rthsl_sva u_rthsl_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_hsl.valid),
    .i_out_ready (o_hsl.ready),
    .i_hue       (o_hsl.hue),
    .i_sat       (o_hsl.saturation),
    .i_def       (o_hsl.hue_defined)
);
`default_nettype wire

// ----- test/rthsl_checker.sv -----
// Checker for the rotated-cube RGB to HSL converter: watches both channels,
// predicts each HSL result from the accepted pixel and compares in order.
// Depends on rthsl_pkg and rthsl_if.
module rthsl_checker
    import rthsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rthsl_pix_if.sink  i_pix,
    rthsl_hsl_if.sink  i_hsl,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] light;
        logic        defined;
    } t_hsl;

    t_hsl hsl_fifo[$];
    int   mismatches;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned a);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > a) bitv >>= 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] cordic_hue(longint x, longint y);
        logic [31:0] acc;
        longint t, xs, ys;
        acc = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = ACC_POS_QTR;
            end else begin
                x = -y; y = t; acc = ACC_NEG_QTR;
            end
        end
        for (int i = 0; i < CordicSteps; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; acc -= ATAN_TAB[i];
            end
        end
        acc = acc + 32'd32768;
        return acc[31:16];
    endfunction

    function automatic t_hsl predict_hsl(logic [7:0] red, logic [7:0] green,
                                         logic [7:0] blue);
        t_hsl o;
        longint r, g, b, sum, lt, p, dd, ad, d, sat;
        longint unsigned m;
        r = red; g = green; b = blue;
        sum = r + g + b;
        lt = (2 * 65536 * sum + 765) / 1530;
        if (lt > 65535) lt = 65535;
        o = '0;
        o.light = lt[15:0];
        if (!(r == g && r == b)) begin
            p = r*r + g*g + b*b - r*g - r*b - g*b;
            dd = 2 * sum - 765;
            ad = dd < 0 ? -dd : dd;
            d = 255;
            if (ad > 255) d = (765 - ad) / 2;
            if (d == 0) d = 1;
            m = isqrt(longint'(p) << 34);
            sat = (m + d) / (2 * d);
            if (sat > 65535) sat = 65535;
            o.sat = sat[15:0];
            o.hue = cordic_hue((2*r - g - b) * (64'sd1 << 24),
                               (g - b) * longint'(SQRT3_Q24));
            o.defined = 1'b1;
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_hsl e;
        if (i_rst_n && i_pix.valid && i_pix.ready)
            hsl_fifo.push_back(predict_hsl(i_pix.red, i_pix.green, i_pix.blue));
        if (i_rst_n && i_hsl.valid && i_hsl.ready) begin
            if (hsl_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = hsl_fifo.pop_front();
                if (e.hue !== i_hsl.hue || e.sat !== i_hsl.saturation ||
                    e.light !== i_hsl.lightness || e.defined !== i_hsl.hue_defined) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp h=%h s=%h l=%h d=%b got h=%h s=%h l=%h d=%b",
                                 e.hue, e.sat, e.light, e.defined, i_hsl.hue,
                                 i_hsl.saturation, i_hsl.lightness, i_hsl.hue_defined);
                end
            end
        end
    end

    assign o_errors  = mismatches;
    assign o_pending = hsl_fifo.size();
endmodule

// ----- test/rgb_to_rotated_hsl_top_tb.sv -----
// Testbench top for rgb_to_rotated_hsl_top: drives pixels with random gaps
// and receiver stalls; rthsl_checker predicts and compares the results.
// Depends on rthsl_pkg, rthsl_if, rthsl_checker and the RTL.
module rgb_to_rotated_hsl_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_pct = 0;    // sender idle chance in percent
    int   stall_pct = 0;   // receiver stall chance in percent
    int   hold_cycles = 0; // long receiver hold-off, counted down below

    rthsl_pix_if pix();
    rthsl_hsl_if hsl();

    rgb_to_rotated_hsl_top uut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .o_hsl(hsl));
    rthsl_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .i_hsl(hsl),
                       .o_errors(errors), .o_pending(pending));

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        pix.valid = 1'b0; pix.red = '0; pix.green = '0; pix.blue = '0;
        hsl.ready = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            hsl.ready <= 1'b0;
        end else begin
            hsl.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one pixel; hold it until the transfer, with random gaps first.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red <= r; pix.green <= g; pix.blue <= b;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    // Mostly random pixels, with greys and near-black/near-white thrown in.
    task automatic random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        case ($urandom_range(5))
            0: begin g = r; b = r; end
            1: begin g = b; end
            2: begin r = 8'($urandom_range(6)); g = 8'($urandom_range(6));
                     b = 8'($urandom_range(6)); end
            3: begin r = 8'(255 - $urandom_range(6)); g = 8'(255 - $urandom_range(6));
                     b = 8'(255 - $urandom_range(6)); end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, greys, hue of pi, saturation clamp near black/white.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd127, 8'd128, 8'd127);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 31 : 0;
            stall_pct = (ph == 2) ? 76 : (ph == 3) ? 31 : 0;
            if (ph == 0) hold_cycles = 200; // long hold-off fills the row
            repeat (330) random_pixel();
        end
        pix.valid <= 1'b0;
        idle_pct = 0; stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
